>>> sv/lhs_pkg.sv
// Shared types, constants and helper functions of the latency histogram monitor.
`default_nettype none

package lhs_pkg;

   // Histogram geometry.
   localparam int HIST_BUCKETS = 64;
   localparam int BIN_BITS     = $clog2(HIST_BUCKETS);

   // Default width of the saturating event and sample counters.
   localparam int COUNTER_BITS_DEF = 48;

   // Word field widths.
   localparam int CMD_BITS   = 3;
   localparam int LAT_BITS   = 64;
   localparam int TOTAL_BITS = 48;
   localparam int FRAC_BITS  = 17;
   localparam int FRAC_SHIFT = 16;

   // Largest value a totals field can carry.
   localparam logic [63:0] TOTAL_MAX = 64'h0000_FFFF_FFFF_FFFF;

   // Shared divider: the dividend covers a 64-bit counter shifted by 16; the
   // divisor covers the 65-bit sum of two counters.
   localparam int DIV_BITS  = 80;
   localparam int DIVR_BITS = 65;

   // Percentile targets are floor(samples * num / PCT_DEN).
   localparam int PCT_DEN = 100;
   localparam int PCT_50  = 50;
   localparam int PCT_90  = 90;
   localparam int PCT_99  = 99;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_RECORD  = 3'd0,
      CMD_ENQUEUE = 3'd1,
      CMD_DROP    = 3'd2,
      CMD_WRITE   = 3'd3,
      CMD_CLEAR   = 3'd4,
      CMD_SUMMARY = 3'd5
   } lhs_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REC_WR,
      ST_DIV_DROP,
      ST_DIV_MEAN,
      ST_WALK,
      ST_DONE
   } lhs_state_type;

   // Position of the highest set bit; zero maps to bucket 0.
   function automatic logic [BIN_BITS-1:0] lhs_log2_bin(input logic [LAT_BITS-1:0] value);
      logic [BIN_BITS-1:0] bin;
      bin = '0;
      for (int i = 1; i < LAT_BITS; i++) begin
         if (value[i]) begin
            bin = BIN_BITS'(i);
         end
      end
      return bin;
   endfunction

endpackage

`default_nettype wire

>>> sv/lhs_if.sv
// Valid/ready channel interfaces for the request and response words.
`default_nettype none

interface lhs_req_if;
   logic                          valid;
   logic                          ready;
   logic [lhs_pkg::CMD_BITS-1:0]  command;
   logic [lhs_pkg::LAT_BITS-1:0]  latency_ns;

   modport source (output valid, output command, output latency_ns, input ready);
   modport sink   (input valid, input command, input latency_ns, output ready);
endinterface

interface lhs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lhs_pkg::TOTAL_BITS-1:0]  enqueued_total;
   logic [lhs_pkg::TOTAL_BITS-1:0]  dropped_total;
   logic [lhs_pkg::TOTAL_BITS-1:0]  written_total;
   logic [lhs_pkg::FRAC_BITS-1:0]   drop_fraction;
   logic [lhs_pkg::LAT_BITS-1:0]    mean_latency;
   logic [lhs_pkg::LAT_BITS-1:0]    median_latency;
   logic [lhs_pkg::LAT_BITS-1:0]    p90_latency;
   logic [lhs_pkg::LAT_BITS-1:0]    p99_latency;

   modport source (output valid, output enqueued_total, output dropped_total,
                   output written_total, output drop_fraction, output mean_latency,
                   output median_latency, output p90_latency, output p99_latency,
                   input ready);
   modport sink   (input valid, input enqueued_total, input dropped_total,
                   input written_total, input drop_fraction, input mean_latency,
                   input median_latency, input p90_latency, input p99_latency,
                   output ready);
endinterface

`default_nettype wire

>>> sv/lhs_divider.sv
// Restoring radix-2 divider that produces one quotient bit per cycle.
`default_nettype none

module lhs_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [lhs_pkg::DIV_BITS-1:0]    dividend,
   input  wire logic [lhs_pkg::DIVR_BITS-1:0]   divisor,
   output logic                                 done,
   output logic [lhs_pkg::DIV_BITS-1:0]         quotient
);

   localparam int CNT_BITS = $clog2(lhs_pkg::DIV_BITS + 1);

   logic                            busy_ff;
   logic                            done_ff;
   logic [CNT_BITS-1:0]             cnt_ff;
   logic [lhs_pkg::DIVR_BITS-1:0]   rem_ff;
   logic [lhs_pkg::DIV_BITS-1:0]    dq_ff;
   logic [lhs_pkg::DIVR_BITS-1:0]   dvs_ff;

   logic                            load;
   logic [lhs_pkg::DIVR_BITS:0]     trial;
   logic [lhs_pkg::DIVR_BITS:0]     diff;
   logic                            fits;

   // A request is taken only once; start stays high until done is seen.
   assign load  = start && !busy_ff && !done_ff;
   assign trial = {rem_ff, dq_ff[lhs_pkg::DIV_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = !diff[lhs_pkg::DIVR_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (load) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(lhs_pkg::DIV_BITS);
         end
      end
   end

   // The dividend shifts out at the top while quotient bits shift in below.
   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[lhs_pkg::DIVR_BITS-1:0] : trial[lhs_pkg::DIVR_BITS-1:0];
         dq_ff  <= {dq_ff[lhs_pkg::DIV_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

`default_nettype wire

>>> sv/latency_histogram_stats_top.sv
// Top level of the log2 latency histogram performance monitor.
// A record word reads its bucket, then writes it back in the REC_WR state; count and clear words
// finish in the idle state. A summary word runs two divisions on the shared radix-2 divider,
// a walk over the bucket memory and a step that loads the result; words are taken only when idle.
// Throughput is set by the single divider and the single memory read port.
// Reset is synchronous and active high; it clears all counters and the bucket valid bits.
`default_nettype none

module latency_histogram_stats_top #(
   parameter int COUNTER_BITS = lhs_pkg::COUNTER_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   lhs_req_if.sink   req_bus,
   lhs_rsp_if.source rsp_bus
);

   localparam int BIN_BITS = lhs_pkg::BIN_BITS;
   localparam int BUCKETS  = lhs_pkg::HIST_BUCKETS;
   // The running sum of bucket counts wraps at 64 bits, as wide counters can exceed it.
   localparam int ACC_BITS = (COUNTER_BITS + BIN_BITS > 64) ? 64 : COUNTER_BITS + BIN_BITS;
   // Room for the running sum or the sample count times 100.
   localparam int SCALE_BITS = ACC_BITS + 7;
   localparam int WALK_BITS = BIN_BITS + 1;
   localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(BUCKETS - 1);

   // ------------------------------------------------------------------
   // Sequencer state and handshake
   // ------------------------------------------------------------------
   lhs_pkg::lhs_state_type state_ff, state_in;

   logic req_fire;
   logic req_ready;
   logic rsp_load;
   logic rsp_valid_ff;

   assign req_bus.ready = req_ready;
   assign req_fire      = req_bus.valid && req_ready;
   assign rsp_bus.valid = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Event counters and the latency sum
   // ------------------------------------------------------------------
   logic [COUNTER_BITS-1:0]       enq_ff, drop_ff, wr_ff, samples_ff;
   logic [lhs_pkg::LAT_BITS-1:0]  total_ff;
   logic [lhs_pkg::LAT_BITS:0]    total_sum;

   assign total_sum = {1'b0, total_ff} + {1'b0, req_bus.latency_ns};

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [lhs_pkg::TOTAL_BITS-1:0] clip_total(
      input logic [COUNTER_BITS-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return (wide > lhs_pkg::TOTAL_MAX) ? '1 : wide[lhs_pkg::TOTAL_BITS-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Bucket memory: one write port and one registered read port. A bucket whose
   // valid bit is clear reads as zero, so reset and the clear command act at once.
   // ------------------------------------------------------------------
   logic [COUNTER_BITS-1:0]  bucket_mem [BUCKETS];
   logic [BUCKETS-1:0]       vld_ff;
   logic [COUNTER_BITS-1:0]  mem_rd_ff;
   logic                     vld_rd_ff;
   logic [BIN_BITS-1:0]      mem_raddr;
   logic                     mem_we;
   logic [BIN_BITS-1:0]      bucket_ff;
   logic [BIN_BITS-1:0]      in_bin;
   logic [COUNTER_BITS-1:0]  bin_val;

   assign in_bin  = lhs_pkg::lhs_log2_bin(req_bus.latency_ns);
   assign bin_val = vld_rd_ff ? mem_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[bucket_ff] <= sat_inc(bin_val);
      end
      mem_rd_ff <= bucket_mem[mem_raddr];
      vld_rd_ff <= vld_ff[mem_raddr];
   end

   // ------------------------------------------------------------------
   // Shared divider and the values it produces
   // ------------------------------------------------------------------
   logic                            div_start;
   logic                            div_done;
   logic [lhs_pkg::DIV_BITS-1:0]    div_dividend;
   logic [lhs_pkg::DIVR_BITS-1:0]   div_divisor;
   logic [lhs_pkg::DIV_BITS-1:0]    div_quot;

   lhs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   logic [lhs_pkg::FRAC_BITS-1:0]  drop_q_ff;
   logic [lhs_pkg::LAT_BITS-1:0]   mean_ff;
   logic                           no_events;
   logic                           no_samples;

   assign no_events  = (enq_ff == '0) && (drop_ff == '0);
   assign no_samples = (samples_ff == '0);

   // ------------------------------------------------------------------
   // Bucket walk: the running sum is checked against all three targets each step.
   // A running sum reaches floor(samples * num / 100) exactly when 100 times the
   // sum reaches samples * num - 99, so the targets need no division.
   // ------------------------------------------------------------------
   logic [WALK_BITS-1:0]   walk_ff;
   logic                   rd_live_ff;
   logic [BIN_BITS-1:0]    rd_idx_ff;
   logic [ACC_BITS-1:0]    acc_ff;
   logic [ACC_BITS-1:0]    acc_sum;
   logic [SCALE_BITS-1:0]  acc_scaled;
   logic [SCALE_BITS-1:0]  thr_ff [3];
   logic [2:0]             found_ff;
   logic [BIN_BITS-1:0]    pbin_ff [3];
   logic [2:0]             hit;

   assign acc_sum    = acc_ff + ACC_BITS'(bin_val);
   assign acc_scaled = SCALE_BITS'(acc_sum) * SCALE_BITS'(lhs_pkg::PCT_DEN);

   // Scaled threshold samples * num - 99, floored at zero.
   function automatic logic [SCALE_BITS-1:0] pct_threshold(
      input logic [COUNTER_BITS-1:0] count, input int num);
      logic [SCALE_BITS-1:0] prod;
      prod = SCALE_BITS'(count) * SCALE_BITS'(num);
      return (prod > SCALE_BITS'(lhs_pkg::PCT_DEN - 1))
             ? prod - SCALE_BITS'(lhs_pkg::PCT_DEN - 1) : '0;
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hit[k] = !found_ff[k] && (acc_scaled >= thr_ff[k]);
      end
   end

   // A percentile reads as 2^bucket, 0 for bucket 0 or no samples, 2^63 if never reached.
   function automatic logic [lhs_pkg::LAT_BITS-1:0] pct_value(
      input logic found, input logic [BIN_BITS-1:0] bin, input logic empty);
      logic [lhs_pkg::LAT_BITS-1:0] value;
      if (empty || (found && bin == '0)) begin
         value = '0;
      end else if (!found) begin
         value = {1'b1, {(lhs_pkg::LAT_BITS-1){1'b0}}};
      end else begin
         value = lhs_pkg::LAT_BITS'(1) << bin;
      end
      return value;
   endfunction

   // ------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lhs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.command == lhs_pkg::CMD_RECORD) begin
                  state_in = lhs_pkg::ST_REC_WR;
               end else if (req_bus.command == lhs_pkg::CMD_SUMMARY) begin
                  state_in = lhs_pkg::ST_DIV_DROP;
               end
            end
         end
         lhs_pkg::ST_REC_WR:   state_in = lhs_pkg::ST_IDLE;
         lhs_pkg::ST_DIV_DROP: if (div_done) state_in = lhs_pkg::ST_DIV_MEAN;
         lhs_pkg::ST_DIV_MEAN: if (div_done) state_in = lhs_pkg::ST_WALK;
         lhs_pkg::ST_WALK: begin
            if (rd_live_ff && rd_idx_ff == LAST_BIN) begin
               state_in = lhs_pkg::ST_DONE;
            end
         end
         lhs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = lhs_pkg::ST_IDLE;
            end
         end
         default: state_in = lhs_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Output decode of the sequencer
   // ------------------------------------------------------------------
   always_comb begin
      req_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      mem_raddr    = bucket_ff;
      mem_we       = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         lhs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mem_raddr = in_bin;
         end
         lhs_pkg::ST_REC_WR: begin
            mem_we = 1'b1;
         end
         lhs_pkg::ST_DIV_DROP: begin
            // dropped * 2^16 over (enqueued + dropped), the sum kept exact
            div_start    = 1'b1;
            div_dividend = lhs_pkg::DIV_BITS'(drop_ff) << lhs_pkg::FRAC_SHIFT;
            div_divisor  = lhs_pkg::DIVR_BITS'(enq_ff) + lhs_pkg::DIVR_BITS'(drop_ff);
         end
         lhs_pkg::ST_DIV_MEAN: begin
            div_start    = 1'b1;
            div_dividend = lhs_pkg::DIV_BITS'(total_ff);
            div_divisor  = lhs_pkg::DIVR_BITS'(samples_ff);
         end
         lhs_pkg::ST_WALK: begin
            mem_raddr = walk_ff[BIN_BITS-1:0];
         end
         lhs_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lhs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
         rd_live_ff   <= 1'b0;
         found_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         rd_live_ff <= (state_ff == lhs_pkg::ST_WALK) && !walk_ff[BIN_BITS];
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == lhs_pkg::ST_DIV_MEAN && div_done) begin
            walk_ff  <= '0;
            found_ff <= '0;
         end else if (state_ff == lhs_pkg::ST_WALK) begin
            if (!walk_ff[BIN_BITS]) begin
               walk_ff <= walk_ff + 1'b1;
            end
            if (rd_live_ff) begin
               found_ff <= found_ff | hit;
            end
         end
      end
   end

   // Counters, the latency sum and bucket valid bits: cleared by reset and by
   // the clear command.
   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_bus.command == lhs_pkg::CMD_CLEAR)) begin
         enq_ff     <= '0;
         drop_ff    <= '0;
         wr_ff      <= '0;
         samples_ff <= '0;
         total_ff   <= '0;
         vld_ff     <= '0;
      end else begin
         if (mem_we) begin
            vld_ff[bucket_ff] <= 1'b1;
         end
         if (req_fire) begin
            case (req_bus.command)
               lhs_pkg::CMD_RECORD: begin
                  samples_ff <= sat_inc(samples_ff);
                  total_ff   <= total_sum[lhs_pkg::LAT_BITS] ? '1
                                : total_sum[lhs_pkg::LAT_BITS-1:0];
               end
               lhs_pkg::CMD_ENQUEUE: enq_ff  <= sat_inc(enq_ff);
               lhs_pkg::CMD_DROP:    drop_ff <= sat_inc(drop_ff);
               lhs_pkg::CMD_WRITE:   wr_ff   <= sat_inc(wr_ff);
               default:              enq_ff  <= enq_ff;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Working registers of the summary and the response word
   // ------------------------------------------------------------------
   logic [lhs_pkg::TOTAL_BITS-1:0]  rsp_enq_ff, rsp_drop_ff, rsp_wr_ff;
   logic [lhs_pkg::FRAC_BITS-1:0]   rsp_frac_ff;
   logic [lhs_pkg::LAT_BITS-1:0]    rsp_mean_ff, rsp_p50_ff, rsp_p90_ff, rsp_p99_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         bucket_ff <= in_bin;
      end
      rd_idx_ff <= walk_ff[BIN_BITS-1:0];
      // The sample count holds still for the whole summary.
      if (state_ff == lhs_pkg::ST_DIV_DROP) begin
         thr_ff[0] <= pct_threshold(samples_ff, lhs_pkg::PCT_50);
         thr_ff[1] <= pct_threshold(samples_ff, lhs_pkg::PCT_90);
         thr_ff[2] <= pct_threshold(samples_ff, lhs_pkg::PCT_99);
      end
      if (div_done) begin
         case (state_ff)
            lhs_pkg::ST_DIV_DROP:
               drop_q_ff <= no_events ? '0 : div_quot[lhs_pkg::FRAC_BITS-1:0];
            lhs_pkg::ST_DIV_MEAN: begin
               mean_ff <= no_samples ? '0 : div_quot[lhs_pkg::LAT_BITS-1:0];
               acc_ff  <= '0;
            end
            default: mean_ff <= mean_ff;
         endcase
      end
      if (state_ff == lhs_pkg::ST_WALK && rd_live_ff) begin
         acc_ff <= acc_sum;
         for (int k = 0; k < 3; k++) begin
            if (hit[k]) begin
               pbin_ff[k] <= rd_idx_ff;
            end
         end
      end
      if (rsp_load) begin
         rsp_enq_ff  <= clip_total(enq_ff);
         rsp_drop_ff <= clip_total(drop_ff);
         rsp_wr_ff   <= clip_total(wr_ff);
         rsp_frac_ff <= drop_q_ff;
         rsp_mean_ff <= mean_ff;
         rsp_p50_ff  <= pct_value(found_ff[0], pbin_ff[0], no_samples);
         rsp_p90_ff  <= pct_value(found_ff[1], pbin_ff[1], no_samples);
         rsp_p99_ff  <= pct_value(found_ff[2], pbin_ff[2], no_samples);
      end
   end

   assign rsp_bus.enqueued_total = rsp_enq_ff;
   assign rsp_bus.dropped_total  = rsp_drop_ff;
   assign rsp_bus.written_total  = rsp_wr_ff;
   assign rsp_bus.drop_fraction  = rsp_frac_ff;
   assign rsp_bus.mean_latency   = rsp_mean_ff;
   assign rsp_bus.median_latency = rsp_p50_ff;
   assign rsp_bus.p90_latency    = rsp_p90_ff;
   assign rsp_bus.p99_latency    = rsp_p99_ff;

`ifndef SYNTH
   // A record word goes straight to the bucket write-back.
   a_rec_write: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.command == lhs_pkg::CMD_RECORD |=> state_ff == lhs_pkg::ST_REC_WR)
      else $error("record word did not reach bucket write-back");

   // A summary word starts the division sequence.
   a_sum_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.command == lhs_pkg::CMD_SUMMARY |=> state_ff == lhs_pkg::ST_DIV_DROP)
      else $error("summary word did not start the divider sequence");

   // Targets are ordered, so a higher percentile is never found before a lower one.
   a_found_order: assert property (@(posedge clock) disable iff (reset)
      (found_ff[2] |-> found_ff[1]) and (found_ff[1] |-> found_ff[0]))
      else $error("percentile found out of order");

   // The divider only finishes while the sequencer is waiting on it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> div_start)
      else $error("divider finished outside a division state");

   // A response word only appears after the summary has completed.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == lhs_pkg::ST_DONE))
      else $error("response raised outside the done state");
`endif

endmodule

`default_nettype wire
